[hw/rtl/pfx_pkg.sv]
// ----------------------------------------------------------------------------
// pfx_pkg: shared types and constants of the printf integer formatter
// Payload structs, the sequencer state type, the digitizer request and
// response groups, ASCII codes and small helper functions.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int BIN_W      = 32;
  localparam int CNT_W      = 5;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int ND_W       = 4;
  localparam int ACC_W      = 7;

  localparam logic [ACC_W-1:0] ACC_MAX = 7'd127;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic [7:0]       fmt_byte;
    logic [BIN_W-1:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_PLACE,
    S_EMIT
  } fmt_state_t;

  typedef struct packed {
    logic             start;
    logic             is_dec;
    logic [BIN_W-1:0] mag;
  } dig_req_t;

  typedef struct packed {
    logic             done;
    logic [DIG_W-1:0] digits;
    logic [ND_W-1:0]  nd;
  } dig_rsp_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'b0000, nib};
    end
    return CH_A - 8'd10 + {4'b0000, nib};
  endfunction

  // Decimal accumulate with saturation: acc * 10 + d, clipped to ACC_MAX.
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] d);
    logic [10:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'b0000000, d};
    return (v > {4'b0000, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

endpackage

[hw/rtl/printf_int_hex_formatter_unit.sv]
// ----------------------------------------------------------------------------
// printf_int_hex_formatter_unit: byte-serial printf engine for %d and %x
// Each input transfer carries one format byte and a 32-bit argument. Literal
// bytes are echoed; a spec with width and precision prints the argument as
// signed decimal or lowercase hex, one character per output transfer.
//
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data, a
// transfer happens when valid is high and stall is low. out_data.last marks
// the final character caused by one input byte; at most MAX_OUT characters
// are sent for one conversion.
// Timing: one input byte is handled at a time. A literal goes through S_EMIT
// into the output register. A conversion passes S_CONV, S_SIZE and S_PLACE
// before its first character; for %d, S_CONV waits on a bit-serial converter
// that takes one argument bit per cycle. After that the sequencer emits one
// character per cycle while the output is not stalled, and the next input
// byte is taken the cycle after the final character is loaded.
// Spec bytes that emit nothing leave the sequencer in S_IDLE.
// Reset: rst_n clears the open spec, the sequencer and the output valid bit.
// Stall: a stalled output holds its character and the sequencer waits.
// ----------------------------------------------------------------------------
module printf_int_hex_formatter_unit import pfx_pkg::*; #(
  parameter int MAX_OUT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int LEN_W = $clog2(MAX_OUT + 1);
  localparam logic [7:0] MAX_OUT_B = 8'(MAX_OUT);

  fmt_state_t state_r, state_nxt;

  logic             in_spec_r, in_spec_nxt;
  logic [ACC_W-1:0] fw_r, fw_nxt;
  logic [ACC_W-1:0] prec_r, prec_nxt;
  logic             dot_r, dot_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic             lit_r, lit_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [ND_W-1:0]  nd_r, nd_nxt;
  logic [ACC_W-1:0] body_r, body_nxt;
  logic [7:0]       total_r, total_nxt;
  logic [7:0]       n_r, n_nxt;
  logic [ACC_W-1:0] spaces_r, spaces_nxt;
  logic [7:0]       z0_r, z0_nxt;
  logic [7:0]       d0_r, d0_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  dig_req_t dig_req;
  dig_rsp_t dig_rsp;

  logic             in_fire;
  logic             out_free;
  logic [7:0]       in_byte;
  logic             arg_neg;
  logic [BIN_W-1:0] arg_mag;
  logic [ACC_W-1:0] nd_ext;
  logic [ACC_W-1:0] body_calc;
  logic             fw_gt;
  logic [7:0]       n_calc;
  logic [ACC_W-1:0] spaces_calc;
  logic [7:0]       z0_calc;
  logic [7:0]       d0_calc;
  logic [LEN_W-1:0] len_calc;
  logic [7:0]       pos8;
  logic [7:0]       di_full;
  logic [ND_W-1:0]  di;
  logic [NUM_DIGITS-1:0][3:0] digit_arr;
  logic [7:0]       emit_char;
  logic             is_last;

  pfx_digitizer u_digitizer (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dig_req),
    .rsp   (dig_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_byte   = in_data.fmt_byte;
  assign arg_neg   = (in_byte == CH_D) && in_data.arg_value[BIN_W-1];
  assign arg_mag   = arg_neg ? (BIN_W'(0) - in_data.arg_value) : in_data.arg_value;

  // Field sizing: body is the zero-padded digit run, total adds the sign.
  assign nd_ext    = ACC_W'(dig_rsp.nd);
  assign body_calc = (zero_r && dot_r) ? prec_r : ((prec_r > nd_ext) ? prec_r : nd_ext);

  // Layout of the output: spaces, then sign, then leading zeros, then digits.
  assign fw_gt       = ({1'b0, fw_r} > total_r);
  assign n_calc      = fw_gt ? {1'b0, fw_r} : total_r;
  assign spaces_calc = fw_gt ? ACC_W'({1'b0, fw_r} - total_r) : '0;
  assign z0_calc     = {1'b0, spaces_calc} + {7'b0000000, neg_r};
  assign d0_calc     = (body_r >= ACC_W'(nd_r))
                     ? z0_calc + {1'b0, body_r} - {4'b0000, nd_r} : z0_calc;
  assign len_calc    = (n_calc > MAX_OUT_B) ? LEN_W'(MAX_OUT) : LEN_W'(n_calc);

  // Digits sit at the tail of the layout, so the index counts back from n.
  assign pos8      = 8'(pos_r);
  assign di_full   = n_r - 8'd1 - pos8;
  assign di        = di_full[ND_W-1:0];
  assign digit_arr = dig_rsp.digits;
  assign is_last   = ((pos_r + LEN_W'(1)) == len_r);

  always_comb begin
    if (lit_r) begin
      emit_char = byte_r;
    end else if (pos8 < {1'b0, spaces_r}) begin
      emit_char = CH_SPACE;
    end else if (pos8 < z0_r) begin
      emit_char = CH_MINUS;
    end else if (pos8 < d0_r) begin
      emit_char = CH_ZERO;
    end else if (di < ND_W'(NUM_DIGITS)) begin
      emit_char = hex_char(digit_arr[di]);
    end else begin
      emit_char = CH_ZERO;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_spec_r) begin
            if (in_byte != CH_PCT && in_byte != CH_NUL) begin
              state_nxt = S_EMIT;
            end
          end else if (in_byte == CH_D || in_byte == CH_X) begin
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (dig_rsp.done) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE:  state_nxt = S_PLACE;
      S_PLACE: state_nxt = (len_calc != '0) ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free && is_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_spec_nxt   = in_spec_r;
    fw_nxt        = fw_r;
    prec_nxt      = prec_r;
    dot_nxt       = dot_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    lit_nxt       = lit_r;
    byte_nxt      = byte_r;
    nd_nxt        = nd_r;
    body_nxt      = body_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    spaces_nxt    = spaces_r;
    z0_nxt        = z0_r;
    d0_nxt        = d0_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    dig_req.start  = 1'b0;
    dig_req.is_dec = (in_byte == CH_D);
    dig_req.mag    = arg_mag;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_spec_r) begin
            if (in_byte == CH_PCT) begin
              in_spec_nxt = 1'b1;
              fw_nxt      = '0;
              prec_nxt    = '0;
              dot_nxt     = 1'b0;
            end else if (in_byte != CH_NUL) begin
              lit_nxt  = 1'b1;
              byte_nxt = in_byte;
              len_nxt  = LEN_W'(1);
              pos_nxt  = '0;
            end
          end else begin
            priority if (in_byte == CH_NUL || in_byte == CH_S) begin
              in_spec_nxt = 1'b0;
              fw_nxt      = '0;
              prec_nxt    = '0;
              dot_nxt     = 1'b0;
            end else if (in_byte == CH_D || in_byte == CH_X) begin
              dig_req.start = 1'b1;
              neg_nxt       = arg_neg;
              zero_nxt      = (in_data.arg_value == '0);
              lit_nxt       = 1'b0;
              pos_nxt       = '0;
            end else if (in_byte == CH_DOT && !dot_r) begin
              dot_nxt = 1'b1;
            end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
              if (dot_r) begin
                prec_nxt = acc_digit(prec_r, in_byte[3:0]);
              end else begin
                fw_nxt = acc_digit(fw_r, in_byte[3:0]);
              end
            end else begin
              in_spec_nxt = in_spec_r;
            end
          end
        end
      end
      S_CONV: begin
        nd_nxt = nd_r;
      end
      S_SIZE: begin
        nd_nxt    = dig_rsp.nd;
        body_nxt  = body_calc;
        total_nxt = {1'b0, body_calc} + {7'b0000000, neg_r};
      end
      S_PLACE: begin
        n_nxt       = n_calc;
        spaces_nxt  = spaces_calc;
        z0_nxt      = z0_calc;
        d0_nxt      = d0_calc;
        len_nxt     = len_calc;
        in_spec_nxt = 1'b0;
        fw_nxt      = '0;
        prec_nxt    = '0;
        dot_nxt     = 1'b0;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.out_char = emit_char;
          out_data_nxt.last     = is_last;
          pos_nxt               = pos_r + LEN_W'(1);
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_spec_r   <= 1'b0;
      fw_r        <= '0;
      prec_r      <= '0;
      dot_r       <= 1'b0;
      lit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_spec_r   <= in_spec_nxt;
      fw_r        <= fw_nxt;
      prec_r      <= prec_nxt;
      dot_r       <= dot_nxt;
      lit_r       <= lit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    byte_r     <= byte_nxt;
    nd_r       <= nd_nxt;
    body_r     <= body_nxt;
    total_r    <= total_nxt;
    n_r        <= n_nxt;
    spaces_r   <= spaces_nxt;
    z0_r       <= z0_nxt;
    d0_r       <= d0_nxt;
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The emit position never runs past the clipped length.
  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> pos_r < len_r)
    else $error("emit position beyond length");

  // Digit positions always address one of the converted digits.
  a_digit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !lit_r && pos8 >= d0_r) |-> di < ND_W'(NUM_DIGITS))
    else $error("digit index out of range");

  // The converter only finishes while the sequencer waits for it.
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dig_rsp.done |-> state_r == S_CONV)
    else $error("digitizer done outside conversion");

  // A literal echo is always a single-character transfer.
  a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && lit_r) |-> len_r == LEN_W'(1))
    else $error("literal echo with wrong length");

endmodule

[hw/rtl/pfx_digitizer.sv]
// ----------------------------------------------------------------------------
// pfx_digitizer: bit-serial binary to digit converter
// Decimal requests run a shift-and-add-3 conversion, one argument bit per
// cycle, into ten BCD digits. Hex requests load the nibbles directly. The
// response also reports the count of significant digits.
// ----------------------------------------------------------------------------
module pfx_digitizer import pfx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dig_req_t req,
  output dig_rsp_t rsp
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [BIN_W-1:0] bin_r;
  logic [DIG_W-1:0] bcd_r;
  logic [DIG_W-1:0] adj;
  logic [ND_W-1:0]  nd;

  // Each BCD digit of 5 or more gets 3 added before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    nd = ND_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        nd = ND_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= req.is_dec;
        done_r <= !req.is_dec;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      bin_r <= req.mag;
      bcd_r <= req.is_dec ? '0 : {{(DIG_W - BIN_W){1'b0}}, req.mag};
    end else if (busy_r) begin
      bcd_r <= {adj[DIG_W-2:0], bin_r[BIN_W-1]};
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.digits = bcd_r;
  assign rsp.nd     = nd;

endmodule

[sim/tb_printf_int_hex_formatter_unit.sv]
// ----------------------------------------------------------------------------
// tb_printf_int_hex_formatter_unit: self-checking bench for the printf engine
// Format bytes with random arguments go through the input channel, and each
// character that comes out is checked against a behavioral model of the
// spec parser and the %d / %x rendering. The run has three traffic phases
// with different idle mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_printf_int_hex_formatter_unit;
  import pfx_pkg::*;

  localparam int CHAR_LIMIT  = 64;
  localparam int HOLD_CYCLES = 200;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  printf_int_hex_formatter_unit #(
    .MAX_OUT(CHAR_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  in_item_t  fmt_backlog[$];
  out_item_t expected_chars[$];
  int        items_queued = 0;
  int        items_taken = 0;
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_asked = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  logic      in_taken = 1'b0;

  // Parser state of the model.
  logic             spec_open = 1'b0;
  logic [ACC_W-1:0] spec_width = '0;
  logic [ACC_W-1:0] spec_prec = '0;
  logic             spec_dot = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [7:0] b);
    int v;
    v = int'(acc) * 10 + int'(b - CH_ZERO);
    return (v > 127) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

  task automatic close_spec();
    spec_open  = 1'b0;
    spec_width = '0;
    spec_prec  = '0;
    spec_dot   = 1'b0;
  endtask

  // Works out the characters one accepted format byte produces.
  task automatic format_byte(input in_item_t item);
    logic [7:0]  text[$];
    logic [7:0]  digs[$];
    logic [7:0]  b;
    logic [31:0] mag;
    logic [31:0] base;
    logic [31:0] dig;
    logic        neg;
    int          nd;
    int          body;
    int          total;
    int          spaces;
    int          count;
    out_item_t   ch;
    b = item.fmt_byte;
    if (!spec_open) begin
      if (b == CH_PCT) begin
        close_spec();
        spec_open = 1'b1;
      end else if (b != CH_NUL) begin
        text.push_back(b);
      end
    end else if (b == CH_NUL || b == CH_S) begin
      close_spec();
    end else if (b == CH_D || b == CH_X) begin
      neg  = (b == CH_D) && item.arg_value[31];
      mag  = neg ? (~item.arg_value + 32'd1) : item.arg_value;
      base = (b == CH_D) ? 32'd10 : 32'd16;
      if (mag == 0) begin
        digs.push_back(CH_ZERO);
      end
      while (mag != 0) begin
        dig = mag % base;
        digs.push_front((dig < 10) ? CH_ZERO + dig[7:0] : CH_A + dig[7:0] - 8'd10);
        mag = mag / base;
      end
      nd = digs.size();
      // A zero value with an explicit dot prints only as many zeros as the
      // precision asks, which may be none at all.
      if (item.arg_value == 0 && spec_dot) begin
        body = int'(spec_prec);
      end else begin
        body = (int'(spec_prec) > nd) ? int'(spec_prec) : nd;
      end
      total  = body + (neg ? 1 : 0);
      spaces = (int'(spec_width) > total) ? int'(spec_width) - total : 0;
      for (int i = 0; i < spaces; i++) text.push_back(CH_SPACE);
      if (neg) text.push_back(CH_MINUS);
      if (body >= nd) begin
        for (int i = 0; i < body - nd; i++) text.push_back(CH_ZERO);
        foreach (digs[i]) text.push_back(digs[i]);
      end
      close_spec();
    end else if (b == CH_DOT && !spec_dot) begin
      spec_dot = 1'b1;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (spec_dot) begin
        spec_prec = add_digit(spec_prec, b);
      end else begin
        spec_width = add_digit(spec_width, b);
      end
    end
    count = (text.size() > CHAR_LIMIT) ? CHAR_LIMIT : text.size();
    for (int k = 0; k < count; k++) begin
      ch.out_char = text[k];
      ch.last     = (k + 1 == count);
      expected_chars.push_back(ch);
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic [31:0] arg);
    in_item_t item;
    item.fmt_byte  = b;
    item.arg_value = arg;
    fmt_backlog.push_back(item);
    items_queued++;
  endtask

  function automatic int digit_count();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 0;
    if (r < 9) return 1;
    return 2;
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom_range(999);
      2: return ~($urandom_range(999));
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly complete specs with random content, the rest literal noise and
  // specs broken up by arbitrary bytes.
  task automatic queue_random(input int target);
    int         start;
    int         sel;
    logic [7:0] conv;
    start = items_queued;
    while (items_queued - start < target) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        push_item(CH_PCT, $urandom);
        repeat (digit_count()) push_item(CH_ZERO + 8'($urandom_range(9)), $urandom);
        if ($urandom_range(1) == 1) begin
          push_item(CH_DOT, $urandom);
          repeat (digit_count()) push_item(CH_ZERO + 8'($urandom_range(9)), $urandom);
        end
        sel = $urandom_range(9);
        if (sel < 4) conv = CH_D;
        else if (sel < 8) conv = CH_X;
        else if (sel < 9) conv = CH_S;
        else conv = CH_NUL;
        push_item(conv, pick_arg());
      end else if (sel < 85) begin
        push_item(8'($urandom_range(255)), $urandom);
      end else begin
        push_item(CH_PCT, $urandom);
        repeat ($urandom_range(1, 3)) push_item(8'($urandom_range(255)), $urandom);
      end
    end
  endtask

  task automatic drain();
    wait (items_taken == items_queued && expected_chars.size() == 0);
  endtask

  // Input side: a new item is offered once the previous one has transferred.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (fmt_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= fmt_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side stall, with an occasional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        format_byte(in_data);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                   $time, out_data.out_char, out_data.last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $display("%0t: out_char expected %h actual %h",
                     $time, want.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 77;
    push_item(8'h41, 32'h0);
    push_item(8'hff, 32'hffff_ffff);
    push_item(CH_PCT, 32'h0);
    push_item(CH_D, 32'h8000_0000);
    push_item(CH_PCT, 32'h0);
    push_item(CH_X, 32'hffff_ffff);
    // Zero with a dot and no precision: only the width spaces come out.
    push_item(CH_PCT, 32'h0);
    push_item(CH_ZERO + 8'd5, 32'h0);
    push_item(CH_DOT, 32'h0);
    push_item(CH_D, 32'h0);
    // Width saturates at 127 and the result is cut at the character limit.
    push_item(CH_PCT, 32'h0);
    repeat (3) push_item(CH_NINE, 32'h0);
    push_item(CH_D, 32'hffff_ffff);
    // Unknown byte, second dot and a percent sign are ignored inside a spec.
    push_item(CH_PCT, 32'h0);
    push_item(8'h71, 32'h0);
    push_item(CH_DOT, 32'h0);
    push_item(CH_ZERO + 8'd2, 32'h0);
    push_item(CH_DOT, 32'h0);
    push_item(CH_PCT, 32'h0);
    push_item(CH_X, 32'h7fff_ffff);
    // A zero byte closes an open spec, and s closes one silently.
    push_item(CH_PCT, 32'h0);
    push_item(CH_ZERO + 8'd3, 32'h0);
    push_item(CH_NUL, 32'h0);
    push_item(CH_PCT, 32'h0);
    push_item(CH_S, 32'h0);
    push_item(CH_NUL, 32'h0);
    queue_random(45);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 18;
    queue_random(50);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    queue_random(45);
    drain();

    repeat (60) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, expected_chars.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[printf_int_hex_formatter_unit.f]
hw/rtl/pfx_pkg.sv
hw/rtl/pfx_digitizer.sv
hw/rtl/printf_int_hex_formatter_unit.sv
sim/tb_printf_int_hex_formatter_unit.sv
